FILE: src/dss_pkg.sv
// Package of the deletion syndrome signature block: sizes, codes, states and control structs.
`timescale 1ns / 1ps
package dss_pkg;

  localparam int MAX_LENGTH           = 32;
  localparam int MAX_CONSTRAINT_COUNT = 8;

  localparam int LEN_W  = $clog2(MAX_LENGTH);
  localparam int CON_W  = $clog2(MAX_CONSTRAINT_COUNT);
  localparam int ADDR_W = CON_W + LEN_W;
  localparam int WORD_W = 32;
  localparam int MOD_W  = 31;
  // Each position adds at most two 32-bit terms.
  localparam int ACC_W  = WORD_W + LEN_W + 2;
  localparam int MAG_W  = ACC_W - 1;
  localparam int CNT_W  = $clog2(MAG_W + 1);

  localparam logic [1:0] FUNC_LOAD_WEIGHT  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_MODULUS = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE      = 2'd2;

  localparam logic CFG_BLOCK_LENGTH     = 1'b0;
  localparam logic CFG_CONSTRAINT_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_START,
    ST_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic               start;
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic [MOD_W-1:0]   modulus;
  } mod_req_t;

  typedef struct packed {
    logic               done;
    logic [MOD_W-1:0]   rem;
  } mod_rsp_t;

endpackage

FILE: src/dss_weight_ram.sv
// Weight memory: one write port, two registered read ports.
`timescale 1ns / 1ps
module dss_weight_ram (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [dss_pkg::ADDR_W-1:0]        waddr_i,
  input  logic [dss_pkg::WORD_W-1:0]        wdata_i,
  input  logic [dss_pkg::ADDR_W-1:0]        raddr_a_i,
  input  logic [dss_pkg::ADDR_W-1:0]        raddr_b_i,
  output logic [dss_pkg::WORD_W-1:0]        rdata_a_o,
  output logic [dss_pkg::WORD_W-1:0]        rdata_b_o
);

  localparam int DEPTH = 2 ** dss_pkg::ADDR_W;

  logic [dss_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

FILE: src/dss_mod_unit.sv
// Bit-serial remainder unit: signed sum modulo a positive modulus, result nonnegative.
`timescale 1ns / 1ps
module dss_mod_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dss_pkg::mod_req_t req_i,
  output dss_pkg::mod_rsp_t rsp_o
);

  logic                        busy_q, done_q, neg_q;
  logic [dss_pkg::CNT_W-1:0]   cnt_q;
  logic [dss_pkg::MAG_W-1:0]   mag_q;
  logic [dss_pkg::MOD_W-1:0]   m_q, rem_q, rem_d;
  logic [dss_pkg::MOD_W:0]     trial, diff;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_q, mag_q[dss_pkg::MAG_W-1]};
    diff  = trial - {1'b0, m_q};
    if (trial >= {1'b0, m_q}) begin
      rem_d = diff[dss_pkg::MOD_W-1:0];
    end else begin
      rem_d = trial[dss_pkg::MOD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= dss_pkg::CNT_W'(dss_pkg::MAG_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == dss_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mag_q <= req_i.mag;
      neg_q <= req_i.neg;
      m_q   <= req_i.modulus;
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[dss_pkg::MAG_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  // Fold a negative remainder back into 0..m-1.
  always_comb begin
    rsp_o.done = done_q;
    if (neg_q && (rem_q != '0)) begin
      rsp_o.rem = m_q - rem_q;
    end else begin
      rsp_o.rem = rem_q;
    end
  end

endmodule

FILE: src/deletion_syndrome_signature_top.sv
// Top level of the deletion syndrome signature block: sequencer, walk datapath and tables.
//
// The block stores a signed 32-bit weight for each of 8 constraints and 32 codeword
// positions, and a modulus for each constraint. A load request (func 0 or 1) is taken
// and gives no result; weights must be loaded before a compute reads them.
// A compute request (func 2) gives one result per constraint in use, in constraint
// order, with last set on the final one. For each constraint the sequencer walks the
// n codeword positions through the two-port weight memory, one position per cycle,
// adding the weight at the original position for every set bit and subtracting the
// weight at the output position for every kept set bit; a bit-serial remainder unit
// then reduces the 39-bit sum modulo the constraint's modulus. The input side stalls
// for the whole compute. Write block_length and constraint_count only while the
// block is idle; values out of range are clamped, the constraint count after
// keeping only the low four bits of the write data.
`timescale 1ns / 1ps
module deletion_syndrome_signature_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [5:0]          cfg_wdata_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [2:0]          constraint_sel_i,
  input  logic [4:0]          bit_position_i,
  input  logic signed [31:0]  load_value_i,
  input  logic [31:0]         codeword_i,
  input  logic [31:0]         delete_mask_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          constraint_index_o,
  output logic [30:0]         delta_o,
  output logic [31:0]         kept_word_o,
  output logic [5:0]          kept_len_o,
  output logic                last_o
);

  localparam int LW = dss_pkg::LEN_W;
  localparam int CW = dss_pkg::CON_W;
  localparam int AW = dss_pkg::ACC_W;

  dss_pkg::state_e state_q, state_d;

  logic [LW:0]                  n_q;
  logic [CW:0]                  r_q;
  logic [dss_pkg::MOD_W-1:0]    mod_q [dss_pkg::MAX_CONSTRAINT_COUNT];

  logic [CW-1:0]                con_q;
  logic [LW:0]                  pos_q, op_q;
  logic [dss_pkg::WORD_W-1:0]   cw_al_q, dm_al_q, cw_wk_q, dm_wk_q;
  logic                         p1_v_q, p1_bit_q, p1_keep_q;
  logic signed [AW-1:0]         acc_q;
  logic [dss_pkg::WORD_W-1:0]   rx_q;
  logic [LW:0]                  rlen_q;
  logic [dss_pkg::MOD_W-1:0]    delta_q;

  logic                         in_acc, out_acc, issue, last_con, walk_done;
  logic                         start_first, start_next, mod_start;
  logic                         cur_bit, cur_keep;
  logic [LW:0]                  shamt;
  logic                         ram_we;
  logic [dss_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [dss_pkg::WORD_W-1:0]   ram_rdata_a, ram_rdata_b;
  logic signed [AW-1:0]         add_term, sub_term, neg_acc;
  logic signed [dss_pkg::WORD_W:0] mod_load;
  logic [5:0]                   cfg_len;
  logic [3:0]                   cfg_cnt;

  dss_pkg::mod_req_t mod_req;
  dss_pkg::mod_rsp_t mod_rsp;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign last_con    = ({1'b0, con_q} + 1'b1) == r_q;
  assign walk_done   = pos_q == (n_q - 1'b1);
  assign start_first = in_acc && (func_i == dss_pkg::FUNC_COMPUTE);
  assign start_next  = out_acc && !last_con;
  assign cur_bit     = cw_wk_q[dss_pkg::WORD_W-1];
  assign cur_keep    = !dm_wk_q[dss_pkg::WORD_W-1];
  // Left-align so that position 0 sits at the top bit.
  assign shamt       = (LW+1)'(dss_pkg::MAX_LENGTH) - n_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dss_pkg::ST_IDLE:  if (start_first) state_d = dss_pkg::ST_WALK;
      dss_pkg::ST_WALK:  if (walk_done) state_d = dss_pkg::ST_DRAIN;
      dss_pkg::ST_DRAIN: state_d = dss_pkg::ST_START;
      dss_pkg::ST_START: state_d = dss_pkg::ST_WAIT;
      dss_pkg::ST_WAIT:  if (mod_rsp.done) state_d = dss_pkg::ST_OUT;
      dss_pkg::ST_OUT: begin
        if (out_acc) begin
          state_d = last_con ? dss_pkg::ST_IDLE : dss_pkg::ST_WALK;
        end
      end
      default:           state_d = dss_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o  = state_q != dss_pkg::ST_IDLE;
    out_valid_o = state_q == dss_pkg::ST_OUT;
    issue       = state_q == dss_pkg::ST_WALK;
    mod_start   = state_q == dss_pkg::ST_START;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers, clamped on write
  always_comb begin
    cfg_len = cfg_wdata_i;
    if (cfg_len < 6'd1) begin
      cfg_len = 6'd1;
    end else if (cfg_len > 6'(dss_pkg::MAX_LENGTH)) begin
      cfg_len = 6'(dss_pkg::MAX_LENGTH);
    end
    cfg_cnt = cfg_wdata_i[3:0];
    if (cfg_cnt < 4'd1) begin
      cfg_cnt = 4'd1;
    end else if (cfg_cnt > 4'(dss_pkg::MAX_CONSTRAINT_COUNT)) begin
      cfg_cnt = 4'(dss_pkg::MAX_CONSTRAINT_COUNT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= (LW+1)'(dss_pkg::MAX_LENGTH);
      r_q <= (CW+1)'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dss_pkg::CFG_BLOCK_LENGTH:     n_q <= cfg_len[LW:0];
        dss_pkg::CFG_CONSTRAINT_COUNT: r_q <= cfg_cnt[CW:0];
        default: ;
      endcase
    end
  end

  // modulus table: a load below one stores one
  assign mod_load = {load_value_i[31], load_value_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < dss_pkg::MAX_CONSTRAINT_COUNT; k++) begin
        mod_q[k] <= dss_pkg::MOD_W'(1);
      end
    end else if (in_acc && (func_i == dss_pkg::FUNC_LOAD_MODULUS) &&
                 (int'(constraint_sel_i) < dss_pkg::MAX_CONSTRAINT_COUNT)) begin
      if (mod_load < 33'sd1) begin
        mod_q[constraint_sel_i[CW-1:0]] <= dss_pkg::MOD_W'(1);
      end else begin
        mod_q[constraint_sel_i[CW-1:0]] <= load_value_i[dss_pkg::MOD_W-1:0];
      end
    end
  end

  // weight memory: address A reads the original position, B the output position
  assign ram_we      = in_acc && (func_i == dss_pkg::FUNC_LOAD_WEIGHT) &&
                       (int'(constraint_sel_i) < dss_pkg::MAX_CONSTRAINT_COUNT) &&
                       (int'(bit_position_i) < dss_pkg::MAX_LENGTH);
  assign ram_waddr   = {constraint_sel_i[CW-1:0], bit_position_i[LW-1:0]};
  assign ram_raddr_a = {con_q, pos_q[LW-1:0]};
  assign ram_raddr_b = {con_q, op_q[LW-1:0]};

  dss_weight_ram u_weight_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (load_value_i),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else begin
      p1_v_q <= issue;
    end
  end

  // Add the original-position weight for a set bit; drop the output-position
  // weight for a kept set bit.
  always_comb begin
    add_term = '0;
    sub_term = '0;
    if (p1_bit_q) begin
      add_term = {{(AW-dss_pkg::WORD_W){ram_rdata_a[dss_pkg::WORD_W-1]}}, ram_rdata_a};
      if (p1_keep_q) begin
        sub_term = {{(AW-dss_pkg::WORD_W){ram_rdata_b[dss_pkg::WORD_W-1]}}, ram_rdata_b};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_first) begin
      cw_al_q <= codeword_i << shamt;
      dm_al_q <= delete_mask_i << shamt;
      con_q   <= '0;
    end
    if (start_first || start_next) begin
      cw_wk_q <= start_first ? (codeword_i << shamt) : cw_al_q;
      dm_wk_q <= start_first ? (delete_mask_i << shamt) : dm_al_q;
      pos_q   <= '0;
      op_q    <= '0;
      acc_q   <= '0;
      rx_q    <= '0;
      rlen_q  <= '0;
    end
    if (start_next) begin
      con_q <= con_q + 1'b1;
    end
    if (issue) begin
      p1_bit_q  <= cur_bit;
      p1_keep_q <= cur_keep;
      cw_wk_q   <= {cw_wk_q[dss_pkg::WORD_W-2:0], 1'b0};
      dm_wk_q   <= {dm_wk_q[dss_pkg::WORD_W-2:0], 1'b0};
      pos_q     <= pos_q + 1'b1;
      if (cur_keep) begin
        op_q   <= op_q + 1'b1;
        rx_q   <= {rx_q[dss_pkg::WORD_W-2:0], cur_bit};
        rlen_q <= rlen_q + 1'b1;
      end
    end
    if (p1_v_q) begin
      acc_q <= acc_q + add_term - sub_term;
    end
    if ((state_q == dss_pkg::ST_WAIT) && mod_rsp.done) begin
      delta_q <= mod_rsp.rem;
    end
  end

  // hand the finished sum to the remainder unit as sign and magnitude
  assign neg_acc         = -acc_q;
  assign mod_req.start   = mod_start;
  assign mod_req.neg     = acc_q[AW-1];
  assign mod_req.mag     = acc_q[AW-1] ? neg_acc[dss_pkg::MAG_W-1:0]
                                       : acc_q[dss_pkg::MAG_W-1:0];
  assign mod_req.modulus = mod_q[con_q];

  dss_mod_unit u_mod_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign constraint_index_o = con_q;
  assign delta_o            = delta_q;
  assign kept_word_o        = rx_q;
  assign kept_len_o         = 6'(rlen_q);
  assign last_o             = last_con;

endmodule

FILE: tb/tb_top.sv
// Testbench for deletion_syndrome_signature_top: directed and random requests checked per field.
`timescale 1ns / 1ps
module tb_top;

  // Watchdog, far above the slowest legal run.
  localparam int CYCLE_LIMIT  = 1_000_000;
  // After the last owed result, wait this long before touching the registers.
  localparam int DRAIN_CYCLES = 16;
  // After the final drain, keep watching this long for stray results.
  localparam int TAIL_CYCLES  = 600;
  // Positions loaded for every constraint; beyond it only constraint 0 has weights,
  // so more than one constraint runs only with a block length up to this.
  localparam int SHORT_LENGTH = 4;
  // The package leaves this code unnamed; the block must swallow it silently.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]  index;
    logic [30:0] delta;
    logic [31:0] word;
    logic [5:0]  len;
    logic        is_last;
  } signature_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_index_i;
  logic [5:0]         cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         func_i;
  logic [2:0]         constraint_sel_i;
  logic [4:0]         bit_position_i;
  logic signed [31:0] load_value_i;
  logic [31:0]        codeword_i;
  logic [31:0]        delete_mask_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         constraint_index_o;
  logic [30:0]        delta_o;
  logic [31:0]        kept_word_o;
  logic [5:0]         kept_len_o;
  logic               last_o;

  // Shadow copy of the block's tables and registers.
  logic signed [31:0] weight_mem [dss_pkg::MAX_CONSTRAINT_COUNT][dss_pkg::MAX_LENGTH];
  logic [30:0]        modulus_mem [dss_pkg::MAX_CONSTRAINT_COUNT];
  int unsigned        cur_length;
  int unsigned        cur_count;

  // Signatures still owed by the block, oldest first.
  signature_t  signature_q[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned cycle_count = 0;

  deletion_syndrome_signature_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .func_i             (func_i),
    .constraint_sel_i   (constraint_sel_i),
    .bit_position_i     (bit_position_i),
    .load_value_i       (load_value_i),
    .codeword_i         (codeword_i),
    .delete_mask_i      (delete_mask_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .constraint_index_o (constraint_index_o),
    .delta_o            (delta_o),
    .kept_word_o        (kept_word_o),
    .kept_len_o         (kept_len_o),
    .last_o             (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("deletion_syndrome_signature_top test failed");
      $finish;
    end
  end

  // Stall the result channel at random; the percentage changes per phase.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Build the signatures of one compute request from the shadow tables.
  function automatic void compute_signatures(input logic [31:0] cw, input logic [31:0] dm);
    logic [31:0] word;
    logic [5:0]  len;
    longint      acc;
    longint      modv;
    longint      rem;
    int          i;
    int          j;
    int          b;
    int          outp;
    signature_t  sig;
    word = '0;
    len  = '0;
    // Compact the kept bits, first position most significant.
    for (i = 0; i < cur_length; i++) begin
      b = cur_length - 1 - i;
      if (!dm[b]) begin
        word = {word[30:0], cw[b]};
        len++;
      end
    end
    for (j = 0; j < cur_count; j++) begin
      acc  = 0;
      outp = 0;
      // Add the weight at the original position, drop the one at the output position.
      for (i = 0; i < cur_length; i++) begin
        b = cur_length - 1 - i;
        if (cw[b]) acc += longint'(weight_mem[j][i]);
        if (!dm[b]) begin
          if (cw[b]) acc -= longint'(weight_mem[j][outp]);
          outp++;
        end
      end
      modv = longint'({33'd0, modulus_mem[j]});
      if (modv < 1) modv = 1;
      rem = acc % modv;
      if (rem < 0) rem += modv;
      sig.index   = 3'(j);
      sig.delta   = 31'(rem);
      sig.word    = word;
      sig.len     = len;
      sig.is_last = (j == cur_count - 1);
      signature_q.insert(signature_q.size(), sig);
    end
  endfunction

  // Advance the shadow state by one accepted request.
  function automatic void apply_request(input logic [1:0] f, input logic [2:0] sel,
                                        input logic [4:0] pos, input logic signed [31:0] val,
                                        input logic [31:0] cw, input logic [31:0] dm);
    case (f)
      dss_pkg::FUNC_LOAD_WEIGHT: begin
        weight_mem[sel][pos] = val;
      end
      dss_pkg::FUNC_LOAD_MODULUS: begin
        // Moduli below one are stored as one.
        modulus_mem[sel] = (val < 1) ? 31'd1 : val[30:0];
      end
      dss_pkg::FUNC_COMPUTE: begin
        compute_signatures(cw, dm);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    error_count++;
    $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // Check every accepted result against the oldest owed signature.
  always @(posedge clk_i) begin : result_check
    signature_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (signature_q.size() == 0) begin
        report_mismatch("result with nothing owed, constraint", 64'd0,
                        64'(constraint_index_o));
      end else begin
        want = signature_q.pop_front();
        if (constraint_index_o !== want.index)
          report_mismatch("constraint_index", 64'(want.index), 64'(constraint_index_o));
        if (delta_o !== want.delta)
          report_mismatch("delta", 64'(want.delta), 64'(delta_o));
        if (kept_word_o !== want.word)
          report_mismatch("kept_word", 64'(want.word), 64'(kept_word_o));
        if (kept_len_o !== want.len)
          report_mismatch("kept_len", 64'(want.len), 64'(kept_len_o));
        if (last_o !== want.is_last)
          report_mismatch("last", 64'(want.is_last), 64'(last_o));
      end
    end
  end

  // Send one request: idle at random, then hold it until the block takes it.
  // Return at the accepting edge with valid still high; the next call or a drain
  // moves it at the following falling edge.
  task automatic send_request(input logic [1:0] f, input logic [2:0] sel,
                              input logic [4:0] pos, input logic signed [31:0] val,
                              input logic [31:0] cw, input logic [31:0] dm);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    func_i           <= f;
    constraint_sel_i <= sel;
    bit_position_i   <= pos;
    load_value_i     <= val;
    codeword_i       <= cw;
    delete_mask_i    <= dm;
    do @(posedge clk_i); while (in_stall_o);
    apply_request(f, sel, pos, val, cw, dm);
  endtask

  // Hold off new requests until every owed signature has come and the block is quiet.
  task automatic drain_requests();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (signature_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; call only after drain_requests.
  task automatic cfg_write(input logic idx, input logic [5:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == dss_pkg::CFG_BLOCK_LENGTH)
      cur_length = (data == 0) ? 1 :
                   ((data > dss_pkg::MAX_LENGTH) ? dss_pkg::MAX_LENGTH : data);
    else
      cur_count = (data[3:0] == 0) ? 1 :
                  ((data[3:0] > dss_pkg::MAX_CONSTRAINT_COUNT) ?
                   dss_pkg::MAX_CONSTRAINT_COUNT : data[3:0]);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Load every weight a compute can reach: all positions of constraint 0, the
  // first few positions of the others.
  task automatic test_weight_preload();
    int j;
    int i;
    for (j = 0; j < dss_pkg::MAX_CONSTRAINT_COUNT; j++)
      for (i = 0; i < ((j == 0) ? dss_pkg::MAX_LENGTH : SHORT_LENGTH); i++)
        send_request(dss_pkg::FUNC_LOAD_WEIGHT, 3'(j), 5'(i), $urandom, $urandom, $urandom);
  endtask

  // Reset state: n = 32, one constraint, modulus one.
  task automatic test_reset_defaults();
    send_request(dss_pkg::FUNC_COMPUTE, 3'd0, 5'd0, 32'sd0, 32'h0000_0000, 32'h0000_0000);
    send_request(dss_pkg::FUNC_COMPUTE, 3'd7, 5'd31, -32'sd1, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  // Modulus loads at the extremes, including values that must be raised to one.
  task automatic test_modulus_loads();
    send_request(dss_pkg::FUNC_LOAD_MODULUS, 3'd0, 5'd0, 32'sh7FFF_FFFF, $urandom, $urandom);
    send_request(dss_pkg::FUNC_LOAD_MODULUS, 3'd1, 5'd0, -32'sd5, $urandom, $urandom);
    send_request(dss_pkg::FUNC_LOAD_MODULUS, 3'd2, 5'd0, 32'sd0, $urandom, $urandom);
    send_request(dss_pkg::FUNC_LOAD_MODULUS, 3'd3, 5'd0, 32'sh8000_0000, $urandom, $urandom);
    send_request(dss_pkg::FUNC_LOAD_MODULUS, 3'd4, 5'd0, 32'sd7, $urandom, $urandom);
    send_request(dss_pkg::FUNC_LOAD_MODULUS, 3'd5, 5'd0, 32'sd1000, $urandom, $urandom);
    send_request(dss_pkg::FUNC_LOAD_MODULUS, 3'd6, 5'd0, 32'sd3, $urandom, $urandom);
    send_request(dss_pkg::FUNC_LOAD_MODULUS, 3'd7, 5'd0, 32'sd65536, $urandom, $urandom);
    drain_requests();
    cfg_write(dss_pkg::CFG_BLOCK_LENGTH, 6'(SHORT_LENGTH));
    cfg_write(dss_pkg::CFG_CONSTRAINT_COUNT, 6'd8);
    send_request(dss_pkg::FUNC_COMPUTE, 3'd0, 5'd0, 32'sd0, $urandom, $urandom);
  endtask

  // Largest and smallest weights under the widest modulus.
  task automatic test_weight_extremes();
    send_request(dss_pkg::FUNC_LOAD_WEIGHT, 3'd0, 5'd0, 32'sh7FFF_FFFF, $urandom, $urandom);
    send_request(dss_pkg::FUNC_LOAD_WEIGHT, 3'd0, 5'd1, 32'sh8000_0000, $urandom, $urandom);
    send_request(dss_pkg::FUNC_LOAD_WEIGHT, 3'd0, 5'd31, 32'sh8000_0000, $urandom, $urandom);
    drain_requests();
    cfg_write(dss_pkg::CFG_BLOCK_LENGTH, 6'd32);
    cfg_write(dss_pkg::CFG_CONSTRAINT_COUNT, 6'd1);
    send_request(dss_pkg::FUNC_COMPUTE, 3'd0, 5'd0, 32'sd0, 32'hFFFF_FFFF, 32'h5555_5555);
  endtask

  // Everything deleted, then only the first or only the last position deleted.
  task automatic test_deletion_patterns();
    send_request(dss_pkg::FUNC_COMPUTE, 3'd0, 5'd0, 32'sd0, $urandom, 32'hFFFF_FFFF);
    send_request(dss_pkg::FUNC_COMPUTE, 3'd0, 5'd0, 32'sd0, $urandom, 32'h8000_0000);
    send_request(dss_pkg::FUNC_COMPUTE, 3'd0, 5'd0, 32'sd0, $urandom, 32'h0000_0001);
  endtask

  // The unused code must give nothing and change nothing.
  task automatic test_unused_func();
    send_request(FUNC_UNUSED, 3'd5, 5'd9, $urandom, $urandom, $urandom);
    send_request(dss_pkg::FUNC_COMPUTE, 3'd0, 5'd0, 32'sd0, $urandom, $urandom);
  endtask

  // Register writes outside the legal range, both ends.
  task automatic test_register_clamp();
    drain_requests();
    cfg_write(dss_pkg::CFG_BLOCK_LENGTH, 6'd0);
    cfg_write(dss_pkg::CFG_CONSTRAINT_COUNT, 6'd0);
    send_request(dss_pkg::FUNC_COMPUTE, 3'd0, 5'd0, 32'sd0, $urandom, 32'h0000_0000);
    drain_requests();
    cfg_write(dss_pkg::CFG_BLOCK_LENGTH, 6'd63);
    send_request(dss_pkg::FUNC_COMPUTE, 3'd0, 5'd0, 32'sd0, $urandom, $urandom);
    drain_requests();
    cfg_write(dss_pkg::CFG_BLOCK_LENGTH, 6'(SHORT_LENGTH - 1));
    cfg_write(dss_pkg::CFG_CONSTRAINT_COUNT, 6'd15);
    send_request(dss_pkg::FUNC_COMPUTE, 3'd0, 5'd0, 32'sd0, $urandom, $urandom);
  endtask

  // Pick new register values while idle: one constraint at any length, or many
  // constraints at a short length.
  task automatic pick_random_config();
    drain_requests();
    case ($urandom_range(3))
      0: begin
        cfg_write(dss_pkg::CFG_BLOCK_LENGTH, 6'($urandom_range(63)));
        cfg_write(dss_pkg::CFG_CONSTRAINT_COUNT, 6'($urandom_range(1)));
      end
      1: begin
        cfg_write(dss_pkg::CFG_BLOCK_LENGTH, 6'd32);
        cfg_write(dss_pkg::CFG_CONSTRAINT_COUNT, 6'd1);
      end
      2: begin
        cfg_write(dss_pkg::CFG_BLOCK_LENGTH, 6'($urandom_range(SHORT_LENGTH)));
        cfg_write(dss_pkg::CFG_CONSTRAINT_COUNT, 6'($urandom_range(63)));
      end
      default: begin
        cfg_write(dss_pkg::CFG_BLOCK_LENGTH, 6'(SHORT_LENGTH));
        cfg_write(dss_pkg::CFG_CONSTRAINT_COUNT, 6'd8);
      end
    endcase
  endtask

  // Random mix of computes and loads under one idling profile.
  task automatic test_random_traffic(input int items, input int sidle, input int ridle);
    int          done;
    int unsigned kind;
    logic [31:0] mask;
    logic [31:0] value;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    pick_random_config();
    done = 0;
    while (done < items) begin
      // Halfway: let the block run dry, then move to new register values.
      if (done == items / 2) pick_random_config();
      kind = $urandom_range(99);
      if (kind < 60) begin
        case ($urandom_range(5))
          0:       mask = 32'h0000_0000;
          1:       mask = 32'hFFFF_FFFF;
          2:       mask = 32'h1 << $urandom_range(31);
          3:       mask = $urandom & $urandom;
          4:       mask = $urandom | $urandom;
          default: mask = $urandom;
        endcase
        send_request(dss_pkg::FUNC_COMPUTE, 3'($urandom), 5'($urandom), $urandom, $urandom,
                     mask);
        done++;
      end else if (kind < 85) begin
        send_request(dss_pkg::FUNC_LOAD_WEIGHT, 3'($urandom_range(7)),
                     5'($urandom_range(31)), $urandom, $urandom, $urandom);
        done++;
      end else if (kind < 95) begin
        case ($urandom_range(3))
          0:       value = 32'($urandom_range(20));
          1:       value = -32'sd1 - 32'($urandom_range(1000));
          2:       value = 32'($urandom_range(100000));
          default: value = $urandom;
        endcase
        send_request(dss_pkg::FUNC_LOAD_MODULUS, 3'($urandom_range(7)), 5'($urandom), value,
                     $urandom, $urandom);
        done++;
      end else begin
        send_request(FUNC_UNUSED, 3'($urandom), 5'($urandom), $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int j;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = 1'b0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    func_i           = dss_pkg::FUNC_LOAD_WEIGHT;
    constraint_sel_i = '0;
    bit_position_i   = '0;
    load_value_i     = '0;
    codeword_i       = '0;
    delete_mask_i    = '0;
    for (j = 0; j < dss_pkg::MAX_CONSTRAINT_COUNT; j++) modulus_mem[j] = 31'd1;
    cur_length = dss_pkg::MAX_LENGTH;
    cur_count  = 1;

    // Directed part runs under the first idling profile.
    send_idle_pct = 14;
    recv_idle_pct = 84;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_weight_preload();
    test_reset_defaults();
    test_modulus_loads();
    test_weight_extremes();
    test_deletion_patterns();
    test_unused_func();
    test_register_clamp();

    test_random_traffic(9, 14, 84);
    test_random_traffic(9, 84, 14);
    test_random_traffic(8, 0, 0);

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("deletion_syndrome_signature_top test passed");
    else
      $display("deletion_syndrome_signature_top test failed");
    $finish;
  end

endmodule

FILE: files.f
src/dss_pkg.sv
src/dss_weight_ram.sv
src/dss_mod_unit.sv
src/deletion_syndrome_signature_top.sv
tb/tb_top.sv
